@@ design/fqir_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqir_pkg: shared types and constants for the queue with indexed remove
// Operation codes, stream field layout and the per-cell control bundle.
// ----------------------------------------------------------------------------
package fqir_pkg;

  typedef enum logic [1:0] {
    OP_ENQUEUE = 2'd0,
    OP_DEQUEUE = 2'd1,
    OP_DISCARD = 2'd2,
    OP_NOP     = 2'd3
  } fqir_op_e;

  // Field widths of the stream payloads
  localparam int unsigned OP_W    = 2;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned POS_W   = 4;
  localparam int unsigned HEAD_W  = 32;
  localparam int unsigned COUNT_W = 5;

  // Input tdata: operation, value, position (lowest first), padded to bytes
  localparam int unsigned IN_OP_LSB   = 0;
  localparam int unsigned IN_VAL_LSB  = IN_OP_LSB + OP_W;
  localparam int unsigned IN_POS_LSB  = IN_VAL_LSB + VALUE_W;
  localparam int unsigned IN_USED_W   = IN_POS_LSB + POS_W;
  localparam int unsigned IN_TDATA_W  = ((IN_USED_W + 7) / 8) * 8;

  // Output tdata: head_value, count, is_empty, error (lowest first)
  localparam int unsigned OUT_HEAD_LSB  = 0;
  localparam int unsigned OUT_CNT_LSB   = OUT_HEAD_LSB + HEAD_W;
  localparam int unsigned OUT_EMPTY_BIT = OUT_CNT_LSB + COUNT_W;
  localparam int unsigned OUT_ERR_BIT   = OUT_EMPTY_BIT + 1;
  localparam int unsigned OUT_USED_W    = OUT_ERR_BIT + 1;
  localparam int unsigned OUT_TDATA_W   = ((OUT_USED_W + 7) / 8) * 8;

  // Per-cell control: load takes the new element, shift takes the neighbor
  typedef struct packed {
    logic load;
    logic shift;
  } fqir_cell_ctrl_t;

endpackage

@@ design/fqir_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqir_cell: one storage cell of the queue chain
// Holds one element; loads a new element, takes its upper neighbor, or holds.
// ----------------------------------------------------------------------------
module fqir_cell #(
  parameter int unsigned ELEM_WIDTH = 32
) (
  input  logic                           clk_i,
  input  fqir_pkg::fqir_cell_ctrl_t      ctrl_i,
  input  logic [ELEM_WIDTH-1:0]          load_data_i,
  input  logic [ELEM_WIDTH-1:0]          next_data_i,
  output logic [ELEM_WIDTH-1:0]          data_o,
  output logic [ELEM_WIDTH-1:0]          data_nxt_o
);

  logic [ELEM_WIDTH-1:0] data_q;
  logic [ELEM_WIDTH-1:0] data_d;

  always_comb begin
    if (ctrl_i.load) begin
      data_d = load_data_i;
    end else if (ctrl_i.shift) begin
      data_d = next_data_i;
    end else begin
      data_d = data_q;
    end
  end

  // payload only, no reset needed
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o     = data_q;
  assign data_nxt_o = data_d;

endmodule

@@ design/fifo_queue_with_indexed_remove_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_queue_with_indexed_remove_top: bounded FIFO with remove-at-position
// A chain of DEPTH cells, cell 0 being the head. Each input transfer carries
// one operation; each produces exactly one status transfer.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Handshake                 Payload (tdata, lowest bit first)
// s_axis    in   s_axis_tvalid/tready      operation[1:0], value[33:2],
//                                          position[37:34], zero pad [39:38]
// m_axis    out  m_axis_tvalid/tready      head_value[31:0], count[36:32],
//                                          is_empty[37], error[38], pad [39]
//
// Cycles: one operation per clock. The whole cell chain updates in the cycle
//   of the input transfer (enqueue loads cell[count], remove shifts every
//   cell at or above the position down by one) and the status lands in the
//   output register at the same edge.
// Stalls: s_axis_tready_o is high while the output register is empty or is
//   being drained in the same cycle, so a back-pressured output stalls input.
// Reset: rst_ni (async, low) clears the element count and the output valid.
//   Cell contents are not reset; only cells below the count are ever read.
// ----------------------------------------------------------------------------
module fifo_queue_with_indexed_remove_top #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned ELEM_WIDTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input transfers: operation, value, position
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [fqir_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  // status transfers: head_value, count, is_empty, error
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  output logic [fqir_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  // compare width for positions, counts and cell indexes
  localparam int unsigned CMP_W = (CNT_W > fqir_pkg::POS_W) ? CNT_W : fqir_pkg::POS_W;

  // --------------------------------------------------------------------------
  // Input field decode
  // --------------------------------------------------------------------------
  logic                               in_fire;
  fqir_pkg::fqir_op_e                 op;
  logic signed [fqir_pkg::VALUE_W-1:0] in_value;
  logic [fqir_pkg::POS_W-1:0]         in_pos;

  assign op       = fqir_pkg::fqir_op_e'(
                      s_axis_tdata_i[fqir_pkg::IN_OP_LSB +: fqir_pkg::OP_W]);
  assign in_value = s_axis_tdata_i[fqir_pkg::IN_VAL_LSB +: fqir_pkg::VALUE_W];
  assign in_pos   = s_axis_tdata_i[fqir_pkg::IN_POS_LSB +: fqir_pkg::POS_W];

  // --------------------------------------------------------------------------
  // Occupancy and operation decisions
  // --------------------------------------------------------------------------
  logic [CNT_W-1:0] count_q;
  logic [CNT_W-1:0] count_d;
  logic             full;
  logic             empty;
  logic             pos_ok;
  logic             do_enq;
  logic             do_rem;
  logic             op_err;
  logic [CMP_W-1:0] rem_pos;

  assign full   = (count_q == CNT_W'(DEPTH));
  assign empty  = (count_q == '0);
  // count never exceeds DEPTH, so this also covers positions past the chain
  assign pos_ok = (CMP_W'(in_pos) < CMP_W'(count_q));

  always_comb begin
    do_enq  = 1'b0;
    do_rem  = 1'b0;
    op_err  = 1'b0;
    rem_pos = '0;
    case (op)
      fqir_pkg::OP_ENQUEUE: begin
        do_enq = !full;
        op_err = full;
      end
      fqir_pkg::OP_DEQUEUE: begin
        do_rem = !empty;
        op_err = empty;
      end
      fqir_pkg::OP_DISCARD: begin
        do_rem  = pos_ok;
        op_err  = !pos_ok;
        rem_pos = CMP_W'(in_pos);
      end
      default: begin
        // no operation
      end
    endcase
  end

  always_comb begin
    count_d = count_q;
    if (do_enq) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_rem) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  // --------------------------------------------------------------------------
  // Cell chain
  // --------------------------------------------------------------------------
  logic signed [ELEM_WIDTH-1:0] elem_in;
  logic [ELEM_WIDTH-1:0]        cell_q   [DEPTH];
  logic [ELEM_WIDTH-1:0]        cell_nxt [DEPTH];

  // value truncated or sign extended to the element width
  assign elem_in = ELEM_WIDTH'(in_value);

  for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
    fqir_pkg::fqir_cell_ctrl_t cell_ctrl;
    logic [ELEM_WIDTH-1:0]     upper;

    assign cell_ctrl.load  = in_fire && do_enq && (count_q == CNT_W'(gi));
    assign cell_ctrl.shift = in_fire && do_rem && (CMP_W'(gi) >= rem_pos);

    if (gi == DEPTH - 1) begin : g_top
      assign upper = cell_q[gi];
    end else begin : g_mid
      assign upper = cell_q[gi+1];
    end

    fqir_cell #(
      .ELEM_WIDTH (ELEM_WIDTH)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (cell_ctrl),
      .load_data_i (elem_in),
      .next_data_i (upper),
      .data_o      (cell_q[gi]),
      .data_nxt_o  (cell_nxt[gi])
    );
  end

  // --------------------------------------------------------------------------
  // Status register
  // --------------------------------------------------------------------------
  logic signed [ELEM_WIDTH-1:0]       head_elem;
  logic [fqir_pkg::HEAD_W-1:0]        head_d;
  logic                               m_valid_q;
  logic [fqir_pkg::HEAD_W-1:0]        out_head_q;
  logic [fqir_pkg::COUNT_W-1:0]       out_count_q;
  logic                               out_empty_q;
  logic                               out_err_q;

  assign head_elem = cell_nxt[0];
  assign head_d    = (count_d != '0) ? fqir_pkg::HEAD_W'(head_elem) : '0;

  assign s_axis_tready_o = !m_valid_q || m_axis_tready_i;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        count_q   <= count_d;
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_head_q  <= head_d;
      out_count_q <= fqir_pkg::COUNT_W'(count_d);
      out_empty_q <= (count_d == '0);
      out_err_q   <= op_err;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;

  always_comb begin
    m_axis_tdata_o = '0;
    m_axis_tdata_o[fqir_pkg::OUT_HEAD_LSB +: fqir_pkg::HEAD_W] = out_head_q;
    m_axis_tdata_o[fqir_pkg::OUT_CNT_LSB +: fqir_pkg::COUNT_W] = out_count_q;
    m_axis_tdata_o[fqir_pkg::OUT_EMPTY_BIT]                    = out_empty_q;
    m_axis_tdata_o[fqir_pkg::OUT_ERR_BIT]                      = out_err_q;
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("element count above depth");

  a_full_refused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (op == fqir_pkg::OP_ENQUEUE) && full
    |=> m_valid_q && out_err_q && (count_q == $past(count_q)))
    else $error("enqueue on full queue not refused");

  a_nop_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (op == fqir_pkg::OP_NOP)
    |=> !out_err_q && (count_q == $past(count_q)))
    else $error("no-operation changed state or flagged error");

  a_empty_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> (out_empty_q == (count_q == '0)))
    else $error("empty flag disagrees with count");

endmodule
